### rtl/core/sasd_pkg.sv
package sasd_pkg;

    localparam int ANGLE_W         = 8;
    localparam int IDX_W           = 20;
    localparam int HW_W            = 5;
    localparam int EMIT_W          = HW_W + 1;
    localparam logic [HW_W-1:0] HW_RESET = 5'd8;

    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_MAX_SAMPLES = 1048576;

    // slope sign codes
    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_UP   = 2'd1;
    localparam logic [1:0] SIGN_DOWN = 2'd2;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] scan_angle;
        logic                      final_sample;
    } sample_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] smoothed_angle;
        logic [IDX_W-1:0]          sample_index;
        logic                      sweep_start;
        logic                      run_last;
        logic                      stream_end;
        logic                      too_short;
    } result_t;

endpackage

### rtl/core/sasd_sample_if.sv
interface sasd_sample_if;
    logic               valid;
    logic               ready;
    sasd_pkg::sample_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/sasd_result_if.sv
interface sasd_result_if;
    logic               valid;
    logic               ready;
    sasd_pkg::result_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/sasd_cfg_if.sv
interface sasd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sasd_pkg::HW_W-1:0]      data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/sasd_ring.sv
module sasd_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [sasd_pkg::ANGLE_W-1:0]   wdata,
    input  logic [AW-1:0]                  raddr,
    output logic [sasd_pkg::ANGLE_W-1:0]   rdata
);

    logic [sasd_pkg::ANGLE_W-1:0] mem [DEPTH];
    logic [sasd_pkg::ANGLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/sasd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module sasd_div #(
    parameter int NW = 15,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [DW:0]     trial;
    logic            fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[NW-1]};
        fits      = trial >= {1'b0, den_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNTW'(NW);
            rem_next = '0;
            quo_next = num;
            den_next = den;
        end
        else if (run_reg)
        begin
            rem_next = fits ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

### rtl/core/scan_angle_smoother_sweep_detector.sv
// Scan-angle box smoother with sweep-start detection.
//
// samples (sink): one scan angle per transaction, final_sample marks the end of a stream.
// results (source): smoothed angles with running sample_index and sweep_start flag.
//   run_last marks the last result of an input transaction, stream_end the last of the
//   stream, too_short a single error result for a stream shorter than one window.
// cfg (sink): writes half_window J (window 2J+1); write only while idle, it restarts
//   the stream.
// Timing: an accepted sample passes the ring step, the sum step and the divider start
//   step, then waits for the bit-serial divider of NW bits (15 at default size); the
//   emit step then registers the first result, and further results follow at one per
//   cycle while results.ready is high. Items go one at a time: the next sample is only
//   taken once the last result is registered, or once the plan yields no result.
//   The window start emits J+1 copies of the first average, the final sample J trailing
//   copies, so one transaction can cause up to 2J+1 results.
// Reset: stream state clears, half_window returns to 8. The ring is not cleared; it is
//   only read at entries written in the current stream.
// Stall: a result waits in the output register while results.ready is low; the
//   sequencer holds in its emit step and takes the next sample once the last result
//   of the transaction is in the output register.
module scan_angle_smoother_sweep_detector #(
    parameter int MAX_WINDOW  = sasd_pkg::DEF_MAX_WINDOW,
    parameter int MAX_SAMPLES = sasd_pkg::DEF_MAX_SAMPLES
) (
    input  logic           clk,
    input  logic           rst_n,
    sasd_sample_if.sink    samples,
    sasd_result_if.source  results,
    sasd_cfg_if.sink       cfg
);
    import sasd_pkg::*;

    // ring addressing and widths derived from the window bound
    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WW   = $clog2(MAX_WINDOW + 1);
    localparam int AXW  = WW + 1;
    localparam int JMAX = (MAX_WINDOW - 1) / 2;
    localparam int SW   = ANGLE_W + $clog2(MAX_WINDOW);
    localparam int NW   = SW + 1;
    localparam int DW   = WW + 1;
    localparam int CW   = $clog2(MAX_SAMPLES);

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RING = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIVS = 3'd3;
    localparam logic [2:0] ST_DIVW = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]                state_reg, state_next;
    logic [HW_W-1:0]           hw_reg, hw_next;
    logic signed [ANGLE_W-1:0] x_reg, x_next;
    logic                      fin_reg, fin_next;
    logic [AW-1:0]             wp_reg, wp_next;
    logic signed [SW-1:0]      sum_reg, sum_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [IDX_W-1:0]          ocnt_reg, ocnt_next;
    logic signed [ANGLE_W-1:0] avg_reg, avg_next;
    logic signed [ANGLE_W-1:0] prev_reg, prev_next;
    logic [1:0]                psign_reg, psign_next;
    logic                      havep_reg, havep_next;
    logic [EMIT_W-1:0]         emit_left_reg, emit_left_next;
    logic                      err_reg, err_next;
    logic                      res_valid_reg, res_valid_next;
    result_t                   res_data_reg, res_data_next;

    logic [HW_W-1:0]           j_eff;
    logic [WW-1:0]             w_val;
    logic                      cnt_ge_w, cnt_eq_w;
    logic [AXW-1:0]            rd_base;
    logic [AW-1:0]             rd_addr;
    logic [ANGLE_W-1:0]        ring_rdata;
    logic                      ring_we;
    logic [SW-1:0]             mag;
    logic [NW-1:0]             div_num;
    logic [DW-1:0]             div_den;
    logic                      div_start, div_done;
    logic [NW-1:0]             div_quot;
    logic signed [ANGLE_W-1:0] q8;
    logic signed [ANGLE_W:0]   diff;
    logic [1:0]                cur_sign;
    logic                      sweep;
    logic                      slot_free;
    logic                      last_emit;
    logic                      restart;
    logic [EMIT_W-1:0]         j6;

    // window size, J limited by the ring depth
    assign j_eff = (int'(hw_reg) > JMAX) ? HW_W'(JMAX) : hw_reg;
    assign w_val = WW'({j_eff, 1'b1});
    assign j6    = EMIT_W'(j_eff);

    assign cnt_ge_w = 32'(cnt_reg) >= 32'(w_val);
    assign cnt_eq_w = 32'(cnt_reg) == 32'(w_val);

    // oldest sample in the window: (wp - w) mod depth
    assign rd_base = AXW'(wp_reg) + AXW'(MAX_WINDOW) - AXW'(w_val);
    assign rd_addr = (AXW'(wp_reg) >= AXW'(w_val)) ? AW'(AXW'(wp_reg) - AXW'(w_val))
                                                   : AW'(rd_base);
    assign ring_we = (state_reg == ST_RING);

    sasd_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (wp_reg),
        .wdata (x_reg),
        .raddr (rd_addr),
        .rdata (ring_rdata)
    );

    // rounded |sum|/w = (2|sum| + w) / 2w
    assign mag       = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign div_num   = {mag, 1'b0} + NW'(w_val);
    assign div_den   = {w_val, 1'b0};
    assign div_start = (state_reg == ST_DIVS) && cnt_ge_w;

    sasd_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign q8 = ANGLE_W'(div_quot);

    // slope tracking on the value about to be emitted
    assign diff     = {avg_reg[ANGLE_W-1], avg_reg} - {prev_reg[ANGLE_W-1], prev_reg};
    assign cur_sign = diff[ANGLE_W] ? SIGN_DOWN : SIGN_UP;
    assign sweep    = havep_reg && (diff != '0) && (psign_reg != SIGN_NONE)
                      && (psign_reg != cur_sign);

    assign slot_free = !res_valid_reg || results.ready;
    assign last_emit = (emit_left_reg == EMIT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        hw_next        = hw_reg;
        x_next         = x_reg;
        fin_next       = fin_reg;
        wp_next        = wp_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        ocnt_next      = ocnt_reg;
        avg_next       = avg_reg;
        prev_next      = prev_reg;
        psign_next     = psign_reg;
        havep_next     = havep_reg;
        emit_left_next = emit_left_reg;
        err_next       = err_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        restart        = 1'b0;

        if (res_valid_reg && results.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg.valid)
                begin
                    hw_next = cfg.data;
                    restart = 1'b1;
                end
                else if (samples.valid)
                begin
                    x_next     = samples.data.scan_angle;
                    fin_next   = samples.data.final_sample;
                    state_next = ST_RING;
                end
            end
            ST_RING:
            begin
                // ring write of the new sample and read of the oldest happen here
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                sum_next = sum_reg + SW'(x_reg)
                           - (cnt_ge_w ? SW'($signed(ring_rdata)) : SW'(0));
                wp_next  = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                if (cnt_reg != CW'(MAX_SAMPLES - 1))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                // plan the results of this transaction
                emit_left_next = (cnt_ge_w ? (cnt_eq_w ? j6 + 1'b1 : EMIT_W'(1)) : '0)
                                 + ((fin_reg && cnt_ge_w) ? j6 : '0);
                err_next       = fin_reg && !cnt_ge_w;
                if (cnt_ge_w)
                begin
                    state_next = ST_DIVW;
                end
                else if (fin_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    avg_next   = sum_reg[SW-1] ? -q8 : q8;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    if (err_reg)
                    begin
                        res_data_next.smoothed_angle = '0;
                        res_data_next.sample_index   = '0;
                        res_data_next.sweep_start    = 1'b0;
                        res_data_next.run_last       = 1'b1;
                        res_data_next.stream_end     = 1'b1;
                        res_data_next.too_short      = 1'b1;
                        err_next                     = 1'b0;
                        restart                      = 1'b1;
                        state_next                   = ST_IDLE;
                    end
                    else
                    begin
                        res_data_next.smoothed_angle = avg_reg;
                        res_data_next.sample_index   = ocnt_reg;
                        res_data_next.sweep_start    = sweep;
                        res_data_next.run_last       = last_emit;
                        res_data_next.stream_end     = last_emit && fin_reg;
                        res_data_next.too_short      = 1'b0;
                        if (havep_reg && (diff != '0))
                        begin
                            psign_next = cur_sign;
                        end
                        prev_next      = avg_reg;
                        havep_next     = 1'b1;
                        ocnt_next      = ocnt_reg + 1'b1;
                        emit_left_next = emit_left_reg - 1'b1;
                        if (last_emit)
                        begin
                            restart    = fin_reg;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (restart)
        begin
            wp_next    = '0;
            sum_next   = '0;
            cnt_next   = '0;
            ocnt_next  = '0;
            avg_next   = '0;
            prev_next  = '0;
            psign_next = SIGN_NONE;
            havep_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hw_reg        <= HW_RESET;
            wp_reg        <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            ocnt_reg      <= '0;
            avg_reg       <= '0;
            prev_reg      <= '0;
            psign_reg     <= SIGN_NONE;
            havep_reg     <= 1'b0;
            emit_left_reg <= '0;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hw_reg        <= hw_next;
            wp_reg        <= wp_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            ocnt_reg      <= ocnt_next;
            avg_reg       <= avg_next;
            prev_reg      <= prev_next;
            psign_reg     <= psign_next;
            havep_reg     <= havep_next;
            emit_left_reg <= emit_left_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        fin_reg      <= fin_next;
        res_data_reg <= res_data_next;
    end

    // config has priority over a sample in the same idle cycle
    assign cfg.ready     = (state_reg == ST_IDLE);
    assign samples.ready = (state_reg == ST_IDLE) && !cfg.valid;
    assign results.valid = res_valid_reg;
    assign results.data  = res_data_reg;

    a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.too_short |->
            results.data.stream_end && results.data.run_last
            && (results.data.smoothed_angle == '0))
        else $error("too_short result without end flags or with nonzero angle");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVW))
        else $error("divider finished outside the wait step");

    a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && !err_reg |-> (emit_left_reg != '0))
        else $error("emit step entered with no result pending");

    a_accept_to_ring: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> (state_reg == ST_RING))
        else $error("sample transaction not followed by ring access");

endmodule
